/* design/lpde_pkg.sv */
`default_nettype none

package lpde_pkg;

    // frame and encoding constants
    localparam int RESET_SLOTS      = 48;
    localparam int MAX_PIXELS       = 1024;
    localparam int BITS_PER_GROUP   = 8;
    localparam int BYTES_PER_PIXEL  = 3;
    localparam int MAX_RESULTS      = 9;
    localparam int MAX_RESET_GROUPS = MAX_RESULTS - BYTES_PER_PIXEL;
    localparam int RESET_GROUPS_RAW = (RESET_SLOTS + BITS_PER_GROUP - 1) / BITS_PER_GROUP;
    localparam int RESET_GROUPS     = (RESET_GROUPS_RAW > MAX_RESET_GROUPS) ?
                                      MAX_RESET_GROUPS : RESET_GROUPS_RAW;
    localparam int GROUPS_LAST      = BYTES_PER_PIXEL + RESET_GROUPS;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int DUTY_W  = 9;
    localparam int LOW_W   = 8;
    localparam int FRAME_W = 11;
    localparam int POS_W   = 10;
    localparam int GRP_W   = 4;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // register map (byte address bit 2 selects the register)
    localparam logic REG_LOW_DUTY     = 1'b0;
    localparam logic REG_FRAME_PIXELS = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [DUTY_W-1:0] t_duty;

    // one queued pixel: its bytes and whether it closes the frame
    typedef struct packed {
        t_byte [BYTES_PER_PIXEL-1:0] bytes;
        logic                        last;
    } t_pix;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

/* design/lpde_front.sv */
`default_nettype none

module lpde_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire  [lpde_pkg::BYTE_W-1:0]  i_first_byte,
    input  wire  [lpde_pkg::BYTE_W-1:0]  i_second_byte,
    input  wire  [lpde_pkg::BYTE_W-1:0]  i_third_byte,
    input  wire  [lpde_pkg::FRAME_W-1:0] i_frame_pixels,
    input  wire  lpde_pkg::t_q_stat      i_q_stat,
    output logic                         o_stall,
    output logic                         o_push,
    output lpde_pkg::t_pix               o_pix
);
    import lpde_pkg::*;

    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic [FRAME_W-1:0] len;
    logic [FRAME_W-1:0] pos_next;
    logic               last;
    logic               accept;

    // frame length saturated into one .. max pixels
    always_comb begin
        priority if (i_frame_pixels == '0) begin
            len = FRAME_W'(1);
        end else if (i_frame_pixels > FRAME_W'(MAX_PIXELS)) begin
            len = FRAME_W'(MAX_PIXELS);
        end else begin
            len = i_frame_pixels;
        end
    end

    // this pixel closes the frame when it reaches the last position
    assign pos_next = {1'b0, r_pos} + FRAME_W'(1);
    assign last     = (pos_next >= len);

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;
    assign o_push  = accept;

    always_comb begin
        o_pix.bytes[0] = i_first_byte;
        o_pix.bytes[1] = i_second_byte;
        o_pix.bytes[2] = i_third_byte;
        o_pix.last     = last;
    end

    // pixel position within the frame
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            n_pos = last ? '0 : pos_next[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

/* design/lpde_queue.sv */
`default_nettype none

module lpde_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire  lpde_pkg::t_pix i_pix,
    input  wire                 i_pop,
    output lpde_pkg::t_pix      o_pix,
    output lpde_pkg::t_q_stat   o_stat
);
    import lpde_pkg::*;

    t_pix               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_pix        = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_pix;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("queue fill count past depth");
`endif

endmodule

`default_nettype wire

/* design/lpde_back.sv */
`default_nettype none

module lpde_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  lpde_pkg::t_pix        i_pix,
    input  wire  lpde_pkg::t_q_stat     i_q_stat,
    input  wire  [lpde_pkg::LOW_W-1:0]  i_low_duty,
    input  wire                         i_stall,
    output logic                        o_pop,
    output logic                        o_valid,
    output lpde_pkg::t_duty [lpde_pkg::BITS_PER_GROUP-1:0] o_duty,
    output logic                        o_is_reset,
    output logic                        o_end_of_frame
);
    import lpde_pkg::*;

    logic [GRP_W-1:0]               r_grp;
    logic                           r_valid;
    t_duty [BITS_PER_GROUP-1:0]     r_duty;
    logic                           r_is_reset;
    logic                           r_eof;
    t_duty [BITS_PER_GROUP-1:0]     n_duty;
    logic                           n_is_reset;
    logic                           n_eof;
    logic                           advance;
    logic                           last_grp;
    logic                           data_grp;
    t_byte                          cur_byte;
    t_duty                          duty_lo;
    t_duty                          duty_hi;

    // load a new group when the output register is free or drains
    assign advance  = !i_q_stat.empty && (!r_valid || !i_stall);
    assign data_grp = (r_grp < GRP_W'(BYTES_PER_PIXEL));
    assign last_grp = i_pix.last ? (r_grp == GRP_W'(GROUPS_LAST - 1))
                                 : (r_grp == GRP_W'(BYTES_PER_PIXEL - 1));
    assign o_pop    = advance && last_grp;

    // byte select and duty encoding, msb first
    assign cur_byte = data_grp ? i_pix.bytes[r_grp[1:0]] : '0;
    assign duty_lo  = {1'b0, i_low_duty};
    assign duty_hi  = {i_low_duty, 1'b0};

    always_comb begin
        for (int i = 0; i < BITS_PER_GROUP; i++) begin
            if (!data_grp) begin
                n_duty[i] = '0;
            end else begin
                n_duty[i] = cur_byte[BITS_PER_GROUP-1-i] ? duty_hi : duty_lo;
            end
        end
        n_is_reset = !data_grp;
        n_eof      = !data_grp && (r_grp == GRP_W'(GROUPS_LAST - 1));
    end

    // group sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_grp <= last_grp ? '0 : r_grp + GRP_W'(1);
            end
            if (advance) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_duty     <= n_duty;
            r_is_reset <= n_is_reset;
            r_eof      <= n_eof;
        end
    end

    assign o_valid        = r_valid;
    assign o_duty         = r_duty;
    assign o_is_reset     = r_is_reset;
    assign o_end_of_frame = r_eof;

`ifndef SYNTH
    a_eof_in_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_eof |-> r_is_reset)
        else $error("end of frame outside reset period");
    a_reset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_is_reset |-> (r_duty == '0))
        else $error("reset group carries nonzero duty");
    a_grp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp < GRP_W'(GROUPS_LAST))
        else $error("group counter out of range");
`endif

endmodule

`default_nettype wire

/* design/led_pixel_pwm_duty_encoder_unit.sv */
// Single-wire serial LED bit encoder: each accepted pixel item (three colour bytes)
// is expanded into three groups of eight 9-bit PWM compare values, msb first;
// a zero bit gives low_duty and a one bit twice that. On the last pixel of a
// frame (frame_pixels, saturated to 1..1024) six all-zero reset groups follow,
// the final one flagged end_of_frame, and the pixel position restarts. The
// output register delivers one group per cycle while i_stall is low, so a
// pixel gives three groups and a frame-ending pixel nine. Pixels enter a
// 4-entry queue in front of that register and are taken every cycle while the
// queue has room. Write the registers only while the block is idle.
`default_nettype none

module led_pixel_pwm_duty_encoder_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // pixel input channel
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [lpde_pkg::BYTE_W-1:0]  i_first_byte,
    input  wire  [lpde_pkg::BYTE_W-1:0]  i_second_byte,
    input  wire  [lpde_pkg::BYTE_W-1:0]  i_third_byte,
    // group output channel
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [lpde_pkg::DUTY_W-1:0]  o_duty_0,
    output logic [lpde_pkg::DUTY_W-1:0]  o_duty_1,
    output logic [lpde_pkg::DUTY_W-1:0]  o_duty_2,
    output logic [lpde_pkg::DUTY_W-1:0]  o_duty_3,
    output logic [lpde_pkg::DUTY_W-1:0]  o_duty_4,
    output logic [lpde_pkg::DUTY_W-1:0]  o_duty_5,
    output logic [lpde_pkg::DUTY_W-1:0]  o_duty_6,
    output logic [lpde_pkg::DUTY_W-1:0]  o_duty_7,
    output logic                         o_is_reset,
    output logic                         o_end_of_frame,
    // register port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [2:0]                   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import lpde_pkg::*;

    logic [LOW_W-1:0]           r_low_duty;
    logic [FRAME_W-1:0]         r_frame_pixels;
    logic                       wr_en;
    logic                       push;
    logic                       pop;
    t_pix                       pix_in;
    t_pix                       pix_out;
    t_q_stat                    q_stat;
    t_duty [BITS_PER_GROUP-1:0] duty;

    // configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_duty     <= LOW_W'(34);
            r_frame_pixels <= FRAME_W'(256);
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_LOW_DUTY:     r_low_duty     <= pwdata[LOW_W-1:0];
                REG_FRAME_PIXELS: r_frame_pixels <= pwdata[FRAME_W-1:0];
                default:          r_low_duty     <= r_low_duty;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2])
            REG_LOW_DUTY:     prdata = {{(32-LOW_W){1'b0}}, r_low_duty};
            REG_FRAME_PIXELS: prdata = {{(32-FRAME_W){1'b0}}, r_frame_pixels};
            default:          prdata = '0;
        endcase
    end

    lpde_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_first_byte   (i_first_byte),
        .i_second_byte  (i_second_byte),
        .i_third_byte   (i_third_byte),
        .i_frame_pixels (r_frame_pixels),
        .i_q_stat       (q_stat),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_pix          (pix_in)
    );

    lpde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pix   (pix_in),
        .i_pop   (pop),
        .o_pix   (pix_out),
        .o_stat  (q_stat)
    );

    lpde_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix          (pix_out),
        .i_q_stat       (q_stat),
        .i_low_duty     (r_low_duty),
        .i_stall        (i_stall),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_duty         (duty),
        .o_is_reset     (o_is_reset),
        .o_end_of_frame (o_end_of_frame)
    );

    assign o_duty_0 = duty[0];
    assign o_duty_1 = duty[1];
    assign o_duty_2 = duty[2];
    assign o_duty_3 = duty[3];
    assign o_duty_4 = duty[4];
    assign o_duty_5 = duty[5];
    assign o_duty_6 = duty[6];
    assign o_duty_7 = duty[7];

endmodule

`default_nettype wire
